@@ design/rsa_pkg.sv @@
// Shared constants, result codes and control types for the slot allocator.
package rsa_pkg;

  localparam int SECTION_COUNT_DEF = 4096;
  localparam int POOL_SLOTS_DEF    = 256;

  localparam int SEC_ID_W = 12;
  localparam int SLOT_O_W = 8;
  localparam int REF_W    = 16;
  localparam int INUSE_W  = 9;
  localparam int STAT_W   = 3;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  localparam logic [STAT_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STAT_W-1:0] ST_REUSED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_HELD     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNMAPPED = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic clear;
    logic capture;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

@@ design/refcounted_slot_allocator_unit.sv @@
// Top level of the reference-counted slot allocator.
// Each item passes through the controller's steps in order: the accepting
// edge reads the section map and the free-queue head, the lookup step reads the
// slot's reference count, and the update step writes map, count and queue and
// loads the result registers. The count read depends on the result of the map
// read. done_o marks the result for one cycle, the first cycle with busy low
// after the item, and cannot be held off. After reset the block sweeps the
// section map, one entry a cycle, with busy high, before it takes the first item.
module refcounted_slot_allocator_unit #(
  parameter int SECTION_COUNT = rsa_pkg::SECTION_COUNT_DEF,
  parameter int POOL_SLOTS    = rsa_pkg::POOL_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [rsa_pkg::SEC_ID_W-1:0] section_id_i,
  output logic                         done_o,
  output logic [rsa_pkg::SLOT_O_W-1:0] slot_index_o,
  output logic [rsa_pkg::REF_W-1:0]    ref_count_o,
  output logic [rsa_pkg::INUSE_W-1:0]  slots_in_use_o,
  output logic [rsa_pkg::STAT_W-1:0]   status_o
);

  import rsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  rsa_dp #(
    .SECTION_COUNT (SECTION_COUNT),
    .POOL_SLOTS    (POOL_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .section_id_i   (section_id_i),
    .sts_o          (sts),
    .done_o         (done_o),
    .slot_index_o   (slot_index_o),
    .ref_count_o    (ref_count_o),
    .slots_in_use_o (slots_in_use_o),
    .status_o       (status_o)
  );

endmodule

@@ design/rsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rsa_ctrl.sv @@
// Sequencer for the slot allocator: clear sweep, lookup and update steps.
module rsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rsa_pkg::sts_t sts_i,
  output rsa_pkg::cmd_t cmd_o,
  output logic          busy
);

  import rsa_pkg::*;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ design/rsa_dp.sv @@
// Datapath: section map, reference counts, free queue and result registers.
module rsa_dp #(
  parameter int SECTION_COUNT = rsa_pkg::SECTION_COUNT_DEF,
  parameter int POOL_SLOTS    = rsa_pkg::POOL_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rsa_pkg::cmd_t                   cmd_i,
  input  logic                            action_i,
  input  logic [rsa_pkg::SEC_ID_W-1:0]    section_id_i,
  output rsa_pkg::sts_t                   sts_o,
  output logic                            done_o,
  output logic [rsa_pkg::SLOT_O_W-1:0]    slot_index_o,
  output logic [rsa_pkg::REF_W-1:0]       ref_count_o,
  output logic [rsa_pkg::INUSE_W-1:0]     slots_in_use_o,
  output logic [rsa_pkg::STAT_W-1:0]      status_o
);

  import rsa_pkg::*;

  localparam int SEC_AW = $clog2(SECTION_COUNT);
  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int MAP_W  = SLOT_W + 1;

  logic              act_q;
  logic [SEC_AW-1:0] sec_q;
  logic              oor_q;
  logic              mapped_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  in_use_q, in_use_d;
  logic [SEC_AW-1:0] clr_q;

  logic [SEC_AW-1:0] sec_addr;
  logic              sec_oor;
  logic [MAP_W-1:0]  map_rdata, map_wdata;
  logic [SEC_AW-1:0] map_waddr;
  logic              map_we;
  logic [SLOT_W-1:0] q_rdata;
  logic              q_we;
  logic [REF_W-1:0]  cnt_rdata, cnt_wdata;
  logic              cnt_we;

  logic              lk_valid;
  logic [SLOT_W-1:0] lk_new_slot, lk_slot;

  logic              upd_map_we;
  logic [MAP_W-1:0]  upd_map_wdata;
  logic [SLOT_W-1:0] res_slot;
  logic [REF_W-1:0]  res_cnt;
  logic [STAT_W-1:0] res_stat;
  logic              pool_full;

  assign sec_addr = SEC_AW'(section_id_i);
  assign sec_oor  = (32'(section_id_i) >= 32'(SECTION_COUNT));

  // lookup step: map entry and queue head are valid now
  assign lk_valid    = map_rdata[SLOT_W];
  assign lk_new_slot = (CNT_W'(head_q) < fill_q) ? q_rdata : head_q;
  assign lk_slot     = lk_valid ? map_rdata[SLOT_W-1:0] : lk_new_slot;

  assign pool_full = (in_use_q >= CNT_W'(POOL_SLOTS));

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    fill_d        = fill_q;
    in_use_d      = in_use_q;
    upd_map_we    = 1'b0;
    upd_map_wdata = '0;
    cnt_we        = 1'b0;
    cnt_wdata     = '0;
    q_we          = 1'b0;
    res_slot      = '0;
    res_cnt       = '0;
    res_stat      = ST_UNMAPPED;
    if (cmd_i.update && !oor_q) begin
      if (!act_q) begin
        if (mapped_q) begin
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_rdata < REF_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
          res_slot  = slot_q;
          res_cnt   = cnt_wdata;
          res_stat  = ST_REUSED;
        end else if (pool_full) begin
          res_stat = ST_EMPTY;
        end else begin
          cnt_we        = 1'b1;
          cnt_wdata     = REF_W'(1);
          upd_map_we    = 1'b1;
          upd_map_wdata = {1'b1, slot_q};
          head_d        = (head_q == SLOT_W'(POOL_SLOTS - 1)) ? '0 : head_q + 1'b1;
          in_use_d      = in_use_q + 1'b1;
          res_slot      = slot_q;
          res_cnt       = REF_W'(1);
          res_stat      = ST_NEW;
        end
      end else if (mapped_q) begin
        if (cnt_rdata > REF_W'(1)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata - 1'b1;
          res_slot  = slot_q;
          res_cnt   = cnt_wdata;
          res_stat  = ST_HELD;
        end else begin
          q_we          = 1'b1;
          tail_d        = (tail_q == SLOT_W'(POOL_SLOTS - 1)) ? '0 : tail_q + 1'b1;
          fill_d        = (fill_q == CNT_W'(POOL_SLOTS)) ? fill_q : fill_q + 1'b1;
          in_use_d      = (in_use_q != '0) ? in_use_q - 1'b1 : in_use_q;
          upd_map_we    = 1'b1;
          upd_map_wdata = '0;
          res_slot      = slot_q;
          res_stat      = ST_FREED;
        end
      end
    end
  end

  assign map_we    = cmd_i.clear | upd_map_we;
  assign map_waddr = cmd_i.clear ? clr_q : sec_q;
  assign map_wdata = cmd_i.clear ? '0 : upd_map_wdata;

  assign sts_o.clear_last = (clr_q == SEC_AW'(SECTION_COUNT - 1));

  rsa_ram #(.WIDTH(MAP_W), .DEPTH(SECTION_COUNT)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (sec_addr),
    .rdata_o (map_rdata)
  );

  rsa_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (slot_q),
    .re_i    (cmd_i.capture),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  rsa_ram #(.WIDTH(REF_W), .DEPTH(POOL_SLOTS)) u_count (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (slot_q),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (lk_slot),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      in_use_q <= '0;
      clr_q    <= '0;
      done_o   <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      in_use_q <= in_use_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      done_o <= cmd_i.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      sec_q <= sec_addr;
      oor_q <= sec_oor;
    end
    if (cmd_i.lookup) begin
      mapped_q <= lk_valid;
      slot_q   <= lk_slot;
    end
    if (cmd_i.update) begin
      slot_index_o   <= SLOT_O_W'(res_slot);
      ref_count_o    <= res_cnt;
      slots_in_use_o <= INUSE_W'(in_use_d);
      status_o       <= res_stat;
    end
  end

endmodule
